// ===== src/mhks_pkg.sv =====
`timescale 1ns / 1ps

package mhks_pkg;

    localparam int NUM_SEEDS = 4;
    localparam int SEED_IDX_W = $clog2(NUM_SEEDS);
    localparam int KMER_W = 64;
    localparam int COUNT_W = 6;
    localparam int HASHES_W = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [COUNT_W-1:0] MAX_K = COUNT_W'(32);

    localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] ALL_ONES = '1;

    localparam logic [CFG_ADDR_W-1:0] REG_KMER_LENGTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HASHES_IN_USE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_ZERO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_ONE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_TWO = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_THREE = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_XOR,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ABSORB,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_XOR,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic                  sel_b;
        logic [SEED_IDX_W-1:0] seed_idx;
    } cmd_t;

    typedef struct packed {
        logic kmer_ready;
        logic eos;
        logic last_seed;
        logic out_free;
    } status_t;

    // v ^ (v >> 33)
    function automatic logic [63:0] xs33(input logic [63:0] v);
        return v ^ (v >> 33);
    endfunction

endpackage

// ===== src/minhash_kmer_signature.sv =====
`timescale 1ns / 1ps

// MinHash k-mer signature. Bases (2-bit codes) stream in on s_; the last k
// of them form a rolling k-mer. Once k bases of the current sequence are in,
// each k-mer is XORed with every active seed, run through the 64-bit
// finalizer (xor-shift 33, multiply, twice, final xor-shift) and folded into
// a per-seed running minimum. The base marked by s_tlast is absorbed first,
// then one word per active seed goes out on m_ (seed number on m_tuser,
// m_tlast on the final one) and the run state clears; a sequence shorter than
// k yields all-ones words. A base that completes a k-mer is hashed for each
// active seed in turn on the single shared 32x32 multiplier, which builds
// each 64-bit product from three partial products. A closing base then sends
// one word per active seed, stalling while m_tready holds off. The user must
// write configuration over cfg_* only while the block is idle; the block
// itself does not enforce this.

module minhash_kmer_signature
    import mhks_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // config: 0 kmer_length, 1 hashes_in_use, 2..5 seed_zero..seed_three
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [1:0] base_code, [7:2] zero
    input  logic                  s_tlast,   // end_of_sequence

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [63:0] min_hash
    output logic [SEED_IDX_W-1:0] m_tuser,   // [1:0] word_index
    output logic                  m_tlast    // last_word
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: absorb, decide, then per seed load / mul A / xor / mul B /
    // compare, and finally word-by-word output.
    mhks_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // Config, k-mer window, minimums, shared multiplier and output register.
    mhks_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .base_code       (s_tdata[1:0]),
        .end_of_sequence (s_tlast),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_index       (m_tuser),
        .out_hash        (m_tdata),
        .out_last        (m_tlast)
    );

endmodule

// ===== src/mhks_ctrl.sv =====
`timescale 1ns / 1ps

module mhks_ctrl
    import mhks_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t                state_reg, state_next;
    logic [SEED_IDX_W-1:0] idx_reg, idx_next;
    logic                  phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                idx_next   = '0;
                phase_next = 1'b0;
                priority if (status.kmer_ready) begin
                    state_next = ST_LOAD;
                end else if (status.eos) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: state_next = ST_M0;
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3: begin
                state_next = phase_reg ? ST_UPDATE : ST_XOR;
            end
            ST_XOR: begin
                phase_next = 1'b1;
                state_next = ST_M0;
            end
            ST_UPDATE: begin
                phase_next = 1'b0;
                if (status.last_seed) begin
                    idx_next   = '0;
                    state_next = status.eos ? ST_EMIT : ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    if (status.last_seed) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.sel_b    = phase_reg;
        cmd.seed_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.op  = s_valid ? OP_ABSORB : OP_NONE;
            end
            ST_DECIDE: cmd.op = OP_NONE;
            ST_LOAD:   cmd.op = OP_LOAD;
            ST_M0:     cmd.op = OP_MUL0;
            ST_M1:     cmd.op = OP_MUL1;
            ST_M2:     cmd.op = OP_MUL2;
            ST_M3:     cmd.op = OP_MUL3;
            ST_XOR:    cmd.op = OP_XOR;
            ST_UPDATE: cmd.op = OP_UPDATE;
            ST_EMIT:   cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== src/mhks_datapath.sv =====
`timescale 1ns / 1ps

module mhks_datapath
    import mhks_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            base_code,
    input  logic                  end_of_sequence,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SEED_IDX_W-1:0] out_index,
    output logic [63:0]           out_hash,
    output logic                  out_last
);

    logic [COUNT_W-1:0]  kmer_length_reg;
    logic [HASHES_W-1:0] hashes_reg;
    logic [63:0]         seed_reg [NUM_SEEDS];

    logic [KMER_W-1:0]   kmer_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                eos_reg;
    logic [63:0]         min_reg [NUM_SEEDS];

    logic [63:0]         v_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         acc_reg;

    logic                out_valid_reg;
    logic [SEED_IDX_W-1:0] out_index_reg;
    logic [63:0]         out_hash_reg;
    logic                out_last_reg;

    logic [COUNT_W-1:0]  k_eff;
    logic [HASHES_W-1:0] n_eff;
    logic [KMER_W-1:0]   kmer_mask;
    logic [KMER_W-1:0]   kmer_next;
    logic [COUNT_W-1:0]  count_next;
    logic [63:0]         mul_const;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_res;
    logic [63:0]         mixed;
    logic                last_seed;
    logic                out_free;

    // effective k: 0 -> 1, above 32 -> 32
    always_comb begin
        priority if (kmer_length_reg == '0) begin
            k_eff = COUNT_W'(1);
        end else if (kmer_length_reg > MAX_K) begin
            k_eff = MAX_K;
        end else begin
            k_eff = kmer_length_reg;
        end
    end

    always_comb begin
        priority if (hashes_reg == '0) begin
            n_eff = HASHES_W'(1);
        end else if (hashes_reg > HASHES_W'(NUM_SEEDS)) begin
            n_eff = HASHES_W'(NUM_SEEDS);
        end else begin
            n_eff = hashes_reg;
        end
    end

    // bit i kept when i < 2k
    always_comb begin
        for (int i = 0; i < KMER_W; i++) begin
            kmer_mask[i] = (7'(i) < {k_eff, 1'b0});
        end
    end

    assign kmer_next  = {kmer_reg[KMER_W-3:0], base_code} & kmer_mask;
    assign count_next = (count_reg >= MAX_K) ? count_reg : count_reg + 1'b1;

    // one 32x32 multiplier; low 64 bits of v*C built over three products
    assign mul_const = cmd.sel_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a     = (cmd.op == OP_MUL2) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b     = (cmd.op == OP_MUL1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_res   = mul_a * mul_b;

    assign mixed     = xs33(acc_reg);
    assign last_seed = ({1'b0, cmd.seed_idx} == n_eff - 1'b1);
    assign out_free  = !out_valid_reg || out_ready;

    assign status.kmer_ready = (count_reg >= k_eff);
    assign status.eos        = eos_reg;
    assign status.last_seed  = last_seed;
    assign status.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= COUNT_W'(16);
            hashes_reg      <= HASHES_W'(4);
            for (int i = 0; i < NUM_SEEDS; i++) begin
                seed_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_KMER_LENGTH:   kmer_length_reg <= cfg_wdata[COUNT_W-1:0];
                REG_HASHES_IN_USE: hashes_reg <= cfg_wdata[HASHES_W-1:0];
                REG_SEED_ZERO:     seed_reg[0] <= cfg_wdata;
                REG_SEED_ONE:      seed_reg[1] <= cfg_wdata;
                REG_SEED_TWO:      seed_reg[2] <= cfg_wdata;
                REG_SEED_THREE:    seed_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_reg  <= '0;
            count_reg <= '0;
            eos_reg   <= 1'b0;
            for (int i = 0; i < NUM_SEEDS; i++) begin
                min_reg[i] <= ALL_ONES;
            end
        end else begin
            if (cmd.op == OP_ABSORB) begin
                kmer_reg  <= kmer_next;
                count_reg <= count_next;
                eos_reg   <= end_of_sequence;
            end
            if (cmd.op == OP_UPDATE && mixed < min_reg[cmd.seed_idx]) begin
                min_reg[cmd.seed_idx] <= mixed;
            end
            if (cmd.op == OP_EMIT && last_seed) begin
                kmer_reg  <= '0;
                count_reg <= '0;
                eos_reg   <= 1'b0;
                for (int i = 0; i < NUM_SEEDS; i++) begin
                    min_reg[i] <= ALL_ONES;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: v_reg <= xs33(kmer_reg ^ seed_reg[cmd.seed_idx]);
            OP_XOR:  v_reg <= mixed;
            OP_MUL0: prod_reg <= mul_res;
            OP_MUL1: begin
                prod_reg <= mul_res;
                acc_reg  <= prod_reg;
            end
            OP_MUL2: begin
                prod_reg <= mul_res;
                acc_reg  <= acc_reg + {prod_reg[31:0], 32'b0};
            end
            OP_MUL3: acc_reg <= acc_reg + {prod_reg[31:0], 32'b0};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_index_reg <= cmd.seed_idx;
            out_hash_reg  <= min_reg[cmd.seed_idx];
            out_last_reg  <= last_seed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_hash  = out_hash_reg;
    assign out_last  = out_last_reg;

endmodule
